### design/fir7_pkg.sv
`timescale 1ns / 1ps
package fir7_pkg;

    localparam int TAPS        = 7;
    localparam int SAMPLE_BITS = 32;
    localparam int STORE_BITS  = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
    localparam int SLOT_W      = $clog2(TAPS);
    localparam int COEF_W      = 17;
    localparam int FRAC_SHIFT  = 17;
    localparam int PROD_W      = STORE_BITS + COEF_W;
    localparam int ACC_W       = PROD_W + $clog2(TAPS);
    localparam int DT_W        = 20;
    localparam int MODE_W      = 2;
    localparam int DEN_W       = DT_W + FRAC_SHIFT;
    localparam int MICRO_W     = 20;
    localparam int NUM_W       = ACC_W + MICRO_W;
    localparam int QUO_W       = 33;
    localparam int CNT_W       = $clog2(QUO_W);
    localparam int SPLIT       = ACC_W / 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MICRO_W-1:0] MICROS_PER_SECOND = MICRO_W'(1000000);

    typedef logic [MODE_W-1:0] t_mode;
    localparam t_mode MODE_DIFF_100 = 2'd0;
    localparam t_mode MODE_DIFF_200 = 2'd1;
    localparam t_mode MODE_LOWPASS  = 2'd2;

    typedef struct packed {
        logic signed [31:0] sample_in;
        logic [DT_W-1:0]    time_step_us;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] filtered_out;
        logic               saturated;
    } t_out_item;

    typedef enum logic [1:0] {
        OP_LOWPASS,
        OP_ZERO_DT,
        OP_DIVIDE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic             neg;
        logic [ACC_W-1:0] mag;
        logic [DT_W-1:0]  dt;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_ACC,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL_LO,
        B_MUL_HI,
        B_SUM,
        B_CHECK,
        B_DIV,
        B_ROUND,
        B_EMIT
    } t_back_state;

    // Q1.17 coefficient sets; tap 0 meets the oldest sample. Unused mode acts as low-pass.
    function automatic logic signed [COEF_W-1:0] coef(t_mode mode, logic [SLOT_W-1:0] tap);
        logic signed [COEF_W-1:0] c;
        c = '0;
        case (mode)
            MODE_DIFF_100: begin
                case (int'(tap))
                    0: c = -17'sd13736;
                    1: c = -17'sd9212;
                    2: c = -17'sd4623;
                    4: c = 17'sd4623;
                    5: c = 17'sd9212;
                    6: c = 17'sd13736;
                    default: c = '0;
                endcase
            end
            MODE_DIFF_200: begin
                case (int'(tap))
                    0: c = -17'sd13368;
                    1: c = -17'sd8923;
                    2: c = -17'sd4465;
                    4: c = 17'sd4465;
                    5: c = 17'sd8923;
                    6: c = 17'sd13368;
                    default: c = '0;
                endcase
            end
            default: begin
                case (int'(tap))
                    0: c = 17'sd3097;
                    1: c = 17'sd12163;
                    2: c = 17'sd30451;
                    3: c = 17'sd39651;
                    4: c = 17'sd30451;
                    5: c = 17'sd12163;
                    6: c = 17'sd3097;
                    default: c = '0;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

### design/fir7_front.sv
`timescale 1ns / 1ps
module fir7_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fir7_pkg::t_mode   i_mode,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fir7_pkg::t_in_item i_in_data,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output fir7_pkg::t_job    o_job
);
    import fir7_pkg::*;

    t_front_state                r_state, n_state;
    logic signed [STORE_BITS-1:0] r_win [TAPS];
    logic [SLOT_W-1:0]           r_slot;
    logic [SLOT_W-1:0]           r_ptr;
    logic [SLOT_W-1:0]           r_tap;
    t_mode                       r_mode;
    logic [DT_W-1:0]             r_dt;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [PROD_W-1:0]    w_prod;
    logic                        w_accept;
    logic                        w_last_tap;
    logic                        w_diff_mode;

    function automatic logic [SLOT_W-1:0] slot_inc(logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(TAPS - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_last_tap  = (r_tap == SLOT_W'(TAPS - 1));
    assign w_prod      = r_win[r_ptr] * coef(r_mode, r_tap);
    assign w_diff_mode = (r_mode == MODE_DIFF_100) || (r_mode == MODE_DIFF_200);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_job_valid = 1'b0;
        case (r_state)
            F_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = F_MUL;
            end
            F_MUL: n_state = F_ACC;
            F_ACC: n_state = w_last_tap ? F_PUSH : F_MUL;
            F_PUSH: begin
                o_job_valid = 1'b1;
                if (i_job_ready) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // delay line and write slot start cleared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) r_win[i] <= '0;
            r_slot <= '0;
        end else if (w_accept) begin
            r_win[r_slot] <= i_in_data.sample_in[STORE_BITS-1:0];
            r_slot        <= slot_inc(r_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    r_ptr  <= slot_inc(r_slot);
                    r_tap  <= '0;
                    r_acc  <= '0;
                    r_mode <= i_mode;
                    r_dt   <= i_in_data.time_step_us;
                end
            end
            F_MUL: r_prod <= w_prod;
            F_ACC: begin
                r_acc <= r_acc + ACC_W'(r_prod);
                if (!w_last_tap) begin
                    r_tap <= r_tap + SLOT_W'(1);
                    r_ptr <= slot_inc(r_ptr);
                end
            end
            default: ;
        endcase
    end

    // classify: low-pass, zero step, or divide
    always_comb begin
        o_job.neg = r_acc[ACC_W-1];
        o_job.mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        o_job.dt  = r_dt;
        if (!w_diff_mode) begin
            o_job.op = OP_LOWPASS;
        end else if (r_dt == '0) begin
            o_job.op = OP_ZERO_DT;
        end else begin
            o_job.op = OP_DIVIDE;
        end
    end

endmodule

### design/fir7_queue.sv
`timescale 1ns / 1ps
module fir7_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  fir7_pkg::t_job i_push_data,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output fir7_pkg::t_job o_pop_data
);
    import fir7_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_push_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= ptr_inc(r_wr);
            if (w_pop)  r_rd <= ptr_inc(r_rd);
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_push_data;
    end

endmodule

### design/fir7_back.sv
`timescale 1ns / 1ps
module fir7_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  fir7_pkg::t_job      i_job,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fir7_pkg::t_out_item o_out_data
);
    import fir7_pkg::*;

    localparam int HI_W  = ACC_W - SPLIT;
    localparam int PP_W  = HI_W + MICRO_W;
    localparam int CMP_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    localparam logic [ACC_W-1:0] POS_LIMIT  = ACC_W'(64'h7FFF_FFFF);
    localparam logic [ACC_W-1:0] NEG_LIMIT  = ACC_W'(64'h8000_0000);
    localparam logic [ACC_W:0]   ROUND_HALF = (ACC_W + 1)'(1) << (FRAC_SHIFT - 1);

    t_back_state      r_state, n_state;
    t_op              r_op;
    logic             r_neg;
    logic [ACC_W-1:0] r_mag;
    logic [DEN_W-1:0] r_den;
    logic [PP_W-1:0]  r_pp;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_res_mag;
    logic             r_res_over;
    logic             r_res_sat;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             w_take;
    logic             w_load;
    logic             w_over;
    logic             w_last_bit;
    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic             w_round_up;
    logic [ACC_W:0]   w_lp_sum;

    function automatic t_out_item clamp(logic neg, logic [ACC_W-1:0] mag, logic over,
                                        logic sat);
        t_out_item  o;
        logic [31:0] w;
        w = mag[31:0];
        if (neg) w = ~w + 32'd1;
        o.saturated = sat;
        if (!neg && (over || mag > POS_LIMIT)) begin
            w           = 32'h7FFF_FFFF;
            o.saturated = 1'b1;
        end else if (neg && (over || mag > NEG_LIMIT)) begin
            w           = 32'h8000_0000;
            o.saturated = 1'b1;
        end
        o.filtered_out = w;
        return o;
    endfunction

    assign w_take     = i_job_valid && o_job_ready;
    assign w_over     = CMP_W'(r_num) >= CMP_W'({r_den, {QUO_W{1'b0}}});
    assign w_last_bit = (r_cnt == CNT_W'(QUO_W - 1));
    assign w_trial    = {r_rem, r_num[QUO_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_den};
    assign w_round_up = {r_rem, 1'b0} >= {1'b0, r_den};
    assign w_lp_sum   = {1'b0, r_mag} + ROUND_HALF;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_job_ready = 1'b0;
        w_load      = 1'b0;
        case (r_state)
            B_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) n_state = (i_job.op == OP_DIVIDE) ? B_MUL_LO : B_ROUND;
            end
            B_MUL_LO: n_state = B_MUL_HI;
            B_MUL_HI: n_state = B_SUM;
            B_SUM:    n_state = B_CHECK;
            B_CHECK:  n_state = w_over ? B_EMIT : B_DIV;
            B_DIV:    n_state = w_last_bit ? B_ROUND : B_DIV;
            B_ROUND:  n_state = B_EMIT;
            B_EMIT: begin
                w_load = !r_out_valid || i_out_ready;
                if (w_load) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (w_take) begin
                    r_op  <= i_job.op;
                    r_neg <= i_job.neg;
                    r_mag <= i_job.mag;
                    r_den <= {i_job.dt, {FRAC_SHIFT{1'b0}}};
                end
            end
            // numerator = magnitude * 1e6, as two partial products
            B_MUL_LO: r_pp <= PP_W'(r_mag[SPLIT-1:0]) * PP_W'(MICROS_PER_SECOND);
            B_MUL_HI: begin
                r_num <= NUM_W'(r_pp);
                r_pp  <= PP_W'(r_mag[ACC_W-1:SPLIT]) * PP_W'(MICROS_PER_SECOND);
            end
            B_SUM: r_num <= r_num + (NUM_W'(r_pp) << SPLIT);
            B_CHECK: begin
                if (w_over) begin
                    r_res_mag  <= '0;
                    r_res_over <= 1'b1;
                    r_res_sat  <= 1'b0;
                end else begin
                    r_rem <= DEN_W'(r_num >> QUO_W);
                    r_cnt <= '0;
                end
            end
            // restoring divide, one quotient bit a cycle
            B_DIV: begin
                r_rem <= w_ge ? DEN_W'(w_trial - {1'b0, r_den}) : DEN_W'(w_trial);
                r_num[QUO_W-1:0] <= {r_num[QUO_W-2:0], w_ge};
                r_cnt <= r_cnt + CNT_W'(1);
            end
            B_ROUND: begin
                case (r_op)
                    OP_ZERO_DT: begin
                        r_res_mag  <= '0;
                        r_res_over <= (r_mag != '0);
                        r_res_sat  <= 1'b1;
                    end
                    OP_DIVIDE: begin
                        r_res_mag  <= ACC_W'(r_num[QUO_W-1:0]) + ACC_W'(w_round_up);
                        r_res_over <= 1'b0;
                        r_res_sat  <= 1'b0;
                    end
                    default: begin
                        r_res_mag  <= ACC_W'(w_lp_sum[ACC_W:FRAC_SHIFT]);
                        r_res_over <= 1'b0;
                        r_res_sat  <= 1'b0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_out_data <= clamp(r_neg, r_res_mag, r_res_over, r_res_sat);
    end

endmodule

### design/fir7_differentiator_lowpass_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Beat
// -------   ---  ------------------------  -----------------------------------
// in        in   i_in_valid / o_in_ready   t_in_item: sample_in, time_step_us
// out       out  o_out_valid / i_out_ready t_out_item: filtered_out, saturated
// cfg       in   i_cfg_we (no wait)        i_cfg_data: filter_mode
//
// The front takes one beat at a time: it accepts, then runs each tap through the
// shared 32x17 multiplier and the accumulator, then hands off to the queue.
// In the differentiator modes the back runs each item through the 33-step
// serial divider; a quotient out of range skips the divide.
// Low-pass and zero time steps skip the multiply and the divide in the back.
// Reset is synchronous, active low, and clears the delay line.
// A two-entry queue and the output register let either side stall on its own.
module fir7_differentiator_lowpass_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  fir7_pkg::t_mode     i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fir7_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fir7_pkg::t_out_item o_out_data
);
    import fir7_pkg::*;

    t_mode r_mode;

    // front -> queue
    logic  w_push_valid;
    logic  w_push_ready;
    t_job  w_push_job;

    // queue -> back
    logic  w_pop_valid;
    logic  w_pop_ready;
    t_job  w_pop_job;

    // hold the mode register; the user must write it only while the block is idle (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DIFF_100;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    // accept a sample, advance the delay line, run the taps, classify the sum
    fir7_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_mode),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (w_push_valid),
        .i_job_ready (w_push_ready),
        .o_job       (w_push_job)
    );

    // buffer classified sums so the front can move on during a divide
    fir7_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_job)
    );

    // scale or divide, round, saturate, and drive the output register
    fir7_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_pop_valid),
        .o_job_ready (w_pop_ready),
        .i_job       (w_pop_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### design/fir7_checker.sv
`timescale 1ns / 1ps
module fir7_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_we,
    input fir7_pkg::t_mode     i_cfg_data,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input fir7_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input fir7_pkg::t_out_item o_out_data
);
    import fir7_pkg::*;

    logic [3:0] r_pending;
    logic       w_in_beat;
    logic       w_out_beat;

    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_out_beat = o_out_valid && i_out_ready;

    // count beats taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 4'(w_in_beat) - 4'(w_out_beat);
        end
    end

    a_no_orphan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_beat |-> (r_pending != '0))
        else $error("result delivered with no sample pending");

    a_front_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> !o_in_ready)
        else $error("input ready right after an accepted sample");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed or dropped");

    logic w_unused;
    assign w_unused = i_cfg_we ^ (^i_cfg_data) ^ (^i_in_data);

endmodule

bind fir7_differentiator_lowpass_top fir7_checker u_checker (.*);

### bench/fir7_response_checker.sv
`timescale 1ns / 1ps
module fir7_response_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  fir7_pkg::t_mode     i_cfg_data,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  fir7_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  fir7_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import fir7_pkg::*;

    // Q1.17 weights per coefficient set; column 0 meets the oldest sample.
    localparam int WEIGHTS [3][7] = '{
        '{-13736, -9212, -4623, 0, 4623, 9212, 13736},
        '{-13368, -8923, -4465, 0, 4465, 8923, 13368},
        '{3097, 12163, 30451, 39651, 30451, 12163, 3097}
    };
    localparam logic [63:0] CLAMP_POS  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] CLAMP_NEG  = 64'h0000_0000_8000_0000;
    localparam logic [63:0] OVERRANGE  = 64'd1 << 40;
    localparam logic [63:0] USEC_PER_S = 64'd1000000;
    localparam logic [63:0] Q1_CEILING = 64'd2148;

    logic signed [31:0] sample_hist [TAPS];
    int                 next_slot;
    t_mode              active_mode;
    t_out_item          queued_outputs [$];
    int                 out_beats;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        out_beats    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns  out beat %0d: %s", $time, out_beats, what);
        o_fail_count++;
    endtask

    // Push one sample into the window and form the filter output for it.
    function automatic t_out_item filter_beat(input t_in_item beat);
        t_out_item   res;
        longint      acc;
        logic [63:0] a, d, q1, r, q2, rem, mag, word;
        logic        neg, sat;
        int          wset, k;
        wset = (active_mode == MODE_DIFF_100) ? 0 :
               (active_mode == MODE_DIFF_200) ? 1 : 2;
        sample_hist[next_slot] = beat.sample_in;
        next_slot = (next_slot + 1) % TAPS;
        acc = 0;
        for (k = 0; k < TAPS; k++)
            acc += longint'(sample_hist[(next_slot + k) % TAPS]) * longint'(WEIGHTS[wset][k]);
        neg = (acc < 0);
        a   = neg ? 64'(-acc) : 64'(acc);
        sat = 1'b0;
        if (wset == 2) begin
            mag = (a + 64'h1_0000) >> 17;
        end else if (beat.time_step_us == '0) begin
            mag = (a == 0) ? 64'd0 : OVERRANGE;
            sat = 1'b1;
        end else begin
            // two-stage divide: integer part, then the fraction scaled by 1e6
            d   = 64'(beat.time_step_us) << 17;
            q1  = a / d;
            r   = (a % d) * USEC_PER_S;
            q2  = r / d;
            rem = r % d;
            if (rem >= d - rem)
                q2 = q2 + 64'd1;
            mag = (q1 >= Q1_CEILING) ? OVERRANGE : q1 * USEC_PER_S + q2;
        end
        if (!neg && mag > CLAMP_POS) begin
            mag = CLAMP_POS;
            sat = 1'b1;
        end
        if (neg && mag > CLAMP_NEG) begin
            mag = CLAMP_NEG;
            sat = 1'b1;
        end
        word = neg ? (64'd0 - mag) : mag;
        res.filtered_out = word[31:0];
        res.saturated    = sat;
        return res;
    endfunction

    task automatic check_beat(input t_out_item got);
        t_out_item want;
        if (queued_outputs.size() == 0) begin
            report_mismatch($sformatf("no result due, got filtered_out=%0d saturated=%0b",
                                      got.filtered_out, got.saturated));
        end else begin
            want = queued_outputs.pop_front();
            if (got.filtered_out !== want.filtered_out)
                report_mismatch($sformatf("filtered_out %0d, want %0d",
                                          got.filtered_out, want.filtered_out));
            if (got.saturated !== want.saturated)
                report_mismatch($sformatf("saturated %0b, want %0b",
                                          got.saturated, want.saturated));
        end
        out_beats++;
    endtask

    always @(posedge i_clk) begin : track
        int k;
        if (!i_rst_n) begin
            for (k = 0; k < TAPS; k++)
                sample_hist[k] = '0;
            next_slot   = 0;
            active_mode = MODE_DIFF_100;
            queued_outputs.delete();
        end else begin
            if (i_cfg_we)
                active_mode = i_cfg_data;
            if (i_in_valid && i_in_ready)
                queued_outputs.push_back(filter_beat(i_in_data));
            if (i_out_valid && i_out_ready)
                check_beat(i_out_data);
        end
        o_pending = queued_outputs.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import fir7_pkg::*;

    // The two-bit mode field has one code without a filter of its own; it
    // must act as the low-pass.
    localparam t_mode           MODE_UNUSED     = 2'd3;
    localparam logic [DT_W-1:0] DT_TOP          = '1;
    localparam int              HOLD_OFF_CYCLES = 600;
    localparam int              SETTLE_CYCLES   = 64;
    localparam int              STALL_LIMIT     = 5000;
    localparam int              PHASES          = 8;
    localparam int              PHASE_BEATS     = 220;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_mode     i_cfg_data;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    int   fail_count;
    int   pending_results;
    logic hold_off_req;   // ask the receiver for one long stall
    logic no_idle;        // run both sides flat out

    fir7_differentiator_lowpass_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    fir7_response_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 80);
    endfunction

    // Pick a sample that sits on or near a corner of the Q16.16 range.
    function automatic logic signed [31:0] corner_sample();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            default: return $urandom();
        endcase
    endfunction

    // Offer one beat on the input channel. Enter and leave at a falling edge;
    // keep valid high when the next beat follows with no gap.
    task automatic send_beat(input logic signed [31:0] s, input logic [DT_W-1:0] dt);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid             = 1'b1;
        i_in_data.sample_in    = s;
        i_in_data.time_step_us = dt;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Drain the block completely, then write the mode register.
    task automatic set_filter_mode(input t_mode m);
        i_in_valid = 1'b0;
        while (pending_results != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = m;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Send one random stretch of samples and add its length to the count.
    task automatic run_sequence(inout int sent);
        int                 kind, len, k, noise;
        logic signed [31:0] base, slope, s;
        int                 nominal;
        logic [DT_W-1:0]    dt;
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
            // smooth trajectory at a sensor-like rate with a little jitter
            len     = $urandom_range(8, 30);
            base    = $signed($urandom()) >>> $urandom_range(4, 14);
            slope   = $signed($urandom()) >>> $urandom_range(12, 22);
            nominal = $urandom_range(2500, 20000);
            for (k = 0; k < len; k++) begin
                noise = $urandom_range(0, 255) - 128;
                s     = base + slope * k + noise;
                dt    = DT_W'(nominal - 100 + $urandom_range(0, 200));
                send_beat(s, dt);
            end
        end else if (kind < 60) begin
            // hold one value long enough to fill the whole window
            len = $urandom_range(7, 12);
            s   = corner_sample();
            for (k = 0; k < len; k++) begin
                dt = ($urandom_range(0, 9) == 0) ? '0 : DT_W'($urandom_range(1000, 20000));
                send_beat(s, dt);
            end
        end else if (kind < 85) begin
            // noise across the full width of both fields
            len = $urandom_range(1, 10);
            for (k = 0; k < len; k++)
                send_beat($urandom(), DT_W'($urandom_range(0, DT_TOP)));
        end else begin
            // corner samples against corner time steps
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++) begin
                case ($urandom_range(0, 3))
                    0: dt = '0;
                    1: dt = DT_W'(1);
                    2: dt = DT_TOP;
                    default: dt = DT_W'($urandom_range(2, 64));
                endcase
                send_beat(corner_sample(), dt);
            end
        end
        sent += len;
    endtask

    // Receiver: random ready pattern, plus one long hold-off on request so
    // the queue and the front fill up and the input stalls.
    initial begin : receiver
        int span;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_off_req) begin
                i_out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                span = no_idle ? 0 : pick_gap();
                if (span > 0) begin
                    i_out_ready = 1'b0;
                    repeat (span) @(negedge i_clk);
                end
                i_out_ready = 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge i_rst_n);
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int    ph, sent, k;
        t_mode m;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = MODE_DIFF_100;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        hold_off_req = 1'b0;
        no_idle      = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. The block comes out of reset in the 100 Hz differentiator.
        send_beat(32'sd0, 0);                   // empty window over zero step: flagged zero
        send_beat(32'sh7FFF_FFFF, 0);           // positive sum over zero step: clamp high
        send_beat(32'sh8000_0000, 1);           // steep fall over one microsecond
        send_beat(32'sh7FFF_FFFF, DT_TOP);      // longest time step
        send_beat(32'sh0001_0000, 10000);       // plain time step; the corners in the window still clamp high
        send_beat(-32'sd1, 1);                  // tiny sample, but the window sum clamps high
        send_beat(32'sh0000_8000, 20'h80000);   // top bit of the time step
        set_filter_mode(MODE_DIFF_200);
        send_beat(32'sh0002_0000, 5000);
        send_beat(32'sh0003_0000, 5000);
        send_beat(32'sh8000_0000, 0);           // negative sum over zero step: clamp low
        set_filter_mode(MODE_LOWPASS);
        // weights sum just above one, so a full window at the top clamps high
        for (k = 0; k < 7; k++)
            send_beat(32'sh7FFF_FFFF, DT_W'($urandom_range(0, DT_TOP)));
        send_beat(32'sh8000_0000, 0);           // low-pass ignores a zero step
        set_filter_mode(MODE_UNUSED);
        send_beat(32'sh0001_0000, 0);
        send_beat(32'sh8000_0000, DT_TOP);

        // Random part: one mode per phase, each phase starting from a drained block.
        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: m = MODE_DIFF_100;
                1: m = MODE_LOWPASS;
                2: m = MODE_DIFF_200;
                3: m = MODE_UNUSED;
                default: m = t_mode'($urandom_range(0, 3));
            endcase
            set_filter_mode(m);
            no_idle = (ph == 3);
            // fast back end in low-pass: a stalled receiver backs up into the input
            if (ph == 1)
                hold_off_req = 1'b1;
            sent = 0;
            while (sent < PHASE_BEATS)
                run_sequence(sent);
        end

        // Let every expected result come out, then allow a few stray cycles.
        i_in_valid = 1'b0;
        while (pending_results != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
